// ===== hdl/ssag_pkg.sv =====
`default_nettype none

package ssag_pkg;

  localparam int CFG_BITS   = 9;
  localparam int INDEX_BITS = 3;
  localparam int NUM_SIZE   = 4;
  localparam int EXT_BITS   = 9;
  localparam int POS_BITS   = 8;
  localparam int START_BITS = 8;
  localparam int SD_BITS    = 3;
  localparam int RANK_BITS  = 4;
  localparam int ADDR_BITS  = 32;
  localparam int VALUE_BITS = 32;

  localparam logic [EXT_BITS-1:0] EXT_MAX = 9'd256;

  typedef enum logic [INDEX_BITS-1:0] {
    REG_RANK         = 3'd0,
    REG_SIZE_0       = 3'd1,
    REG_SIZE_1       = 3'd2,
    REG_SIZE_2       = 3'd3,
    REG_SIZE_3       = 3'd4,
    REG_SLICE_DIM    = 3'd5,
    REG_SLICE_START  = 3'd6,
    REG_SLICE_LENGTH = 3'd7
  } reg_index_t;

  // normalized configuration, shared by front and back
  typedef struct packed {
    logic [RANK_BITS-1:0]                rank;
    logic                                sd_valid;
    logic [SD_BITS-1:0]                  sd;
    logic [START_BITS-1:0]               start;
    logic [EXT_BITS-1:0]                 slice_len;
    logic [NUM_SIZE-1:0][EXT_BITS-1:0]   size;
  } cfg_t;

  typedef struct packed {
    logic last;
    logic oor;
  } flags_t;

  typedef struct packed {
    logic [1:0] count;
    logic       full;
    logic       empty;
  } queue_status_t;

  // zero reads as one, anything past 256 saturates
  function automatic logic [EXT_BITS-1:0] sat_extent(input logic [EXT_BITS-1:0] v);
    logic [EXT_BITS-1:0] r;
    r = v;
    if (v == '0) r = 9'd1;
    else if (v > EXT_MAX) r = EXT_MAX;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/ssag_front.sv =====
`default_nettype none

module ssag_front #(
  parameter int MAX_RANK = 4
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire ssag_pkg::cfg_t                       cfg,
  input  wire logic                                 accept,
  output logic [MAX_RANK*ssag_pkg::EXT_BITS-1:0]    idx,
  output ssag_pkg::flags_t                          flags
);
  import ssag_pkg::*;

  logic [POS_BITS-1:0] position      [MAX_RANK];
  logic [POS_BITS-1:0] position_next [MAX_RANK];
  logic [EXT_BITS-1:0] size_ext      [MAX_RANK];
  logic [EXT_BITS-1:0] extent        [MAX_RANK];
  logic [EXT_BITS-1:0] pos_inc       [MAX_RANK];
  logic [EXT_BITS-1:0] dim_idx       [MAX_RANK];
  logic [MAX_RANK-1:0] in_rank;
  logic [MAX_RANK-1:0] is_slice;
  logic [MAX_RANK-1:0] wrap;
  logic [MAX_RANK-1:0] carry;
  logic [MAX_RANK-1:0] oor_dim;

  for (genvar g = 0; g < MAX_RANK; g++) begin : g_dim
    if (g < NUM_SIZE) begin : g_sz
      assign size_ext[g] = cfg.size[g];
    end else begin : g_one
      assign size_ext[g] = 9'd1;
    end
    assign in_rank[g]  = RANK_BITS'(g) < cfg.rank;
    assign is_slice[g] = cfg.sd_valid && (cfg.sd == SD_BITS'(g));
    assign extent[g]   = is_slice[g] ? cfg.slice_len : size_ext[g];
    assign pos_inc[g]  = {1'b0, position[g]} + 9'd1;
    assign wrap[g]     = pos_inc[g] >= extent[g];
    assign dim_idx[g]  = {1'b0, position[g]} + (is_slice[g] ? {1'b0, cfg.start} : 9'd0);
    assign oor_dim[g]  = is_slice[g] && (dim_idx[g] >= size_ext[g]);
    assign idx[g*EXT_BITS +: EXT_BITS] = dim_idx[g];
    assign position_next[g] = (in_rank[g] && carry[g])
                              ? (wrap[g] ? '0 : pos_inc[g][POS_BITS-1:0])
                              : position[g];
  end

  // carry ripples outward from the innermost dimension
  always_comb begin
    carry[MAX_RANK-1] = 1'b1;
    for (int d = MAX_RANK - 2; d >= 0; d--) begin
      carry[d] = carry[d+1] & (!in_rank[d+1] | wrap[d+1]);
    end
  end

  assign flags.last = carry[0] & wrap[0];
  assign flags.oor  = |oor_dim;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int d = 0; d < MAX_RANK; d++) position[d] <= '0;
    end else if (accept) begin
      for (int d = 0; d < MAX_RANK; d++) position[d] <= position_next[d];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ssag_queue.sv =====
`default_nettype none

module ssag_queue #(
  parameter int WIDTH = 72
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    push,
  input  wire logic [WIDTH-1:0]        wdata,
  input  wire logic                    pop,
  output logic [WIDTH-1:0]             rdata,
  output ssag_pkg::queue_status_t      status
);
  import ssag_pkg::*;

  logic [WIDTH-1:0] entry [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign rdata        = entry[rd_ptr];
  assign status.count = count;
  assign status.full  = count == 2'd2;
  assign status.empty = count == 2'd0;

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ssag_back.sv =====
`default_nettype none

module ssag_back #(
  parameter int MAX_RANK = 4
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire ssag_pkg::cfg_t                        cfg,
  input  wire logic                                  in_valid,
  input  wire logic [MAX_RANK*ssag_pkg::EXT_BITS-1:0] in_idx,
  input  wire logic [ssag_pkg::VALUE_BITS-1:0]       in_value,
  input  wire ssag_pkg::flags_t                      in_flags,
  output logic                                       in_take,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic [ssag_pkg::ADDR_BITS-1:0]             out_address,
  output logic [ssag_pkg::VALUE_BITS-1:0]            out_value,
  output ssag_pkg::flags_t                           out_flags
);
  import ssag_pkg::*;

  localparam int LAST = MAX_RANK - 1;

  logic [MAX_RANK-1:0]            valid;
  logic [MAX_RANK-1:0]            en;
  logic [ADDR_BITS-1:0]           acc   [MAX_RANK];
  logic [MAX_RANK*EXT_BITS-1:0]   idx   [MAX_RANK];
  logic [VALUE_BITS-1:0]          value [MAX_RANK];
  flags_t                         flags [MAX_RANK];

  // a stage loads when it is empty or the one after it moves on
  always_comb begin
    en[LAST] = !valid[LAST] | out_ready;
    for (int s = LAST - 1; s >= 0; s--) begin
      en[s] = !valid[s] | en[s+1];
    end
  end

  assign in_take = en[0] & in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else if (en[0]) begin
      valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      acc[0]   <= ADDR_BITS'(in_idx[EXT_BITS-1:0]);
      idx[0]   <= in_idx;
      value[0] <= in_value;
      flags[0] <= in_flags;
    end
  end

  // horner step per stage in rank: acc = acc * size + index, else acc passes on
  for (genvar s = 1; s < MAX_RANK; s++) begin : g_stage
    logic [EXT_BITS-1:0]           size_s;
    logic [ADDR_BITS+EXT_BITS-1:0] prod;
    logic [ADDR_BITS-1:0]          step;
    logic                          active;

    if (s < NUM_SIZE) begin : g_sz
      assign size_s = cfg.size[s];
    end else begin : g_one
      assign size_s = 9'd1;
    end
    assign active = RANK_BITS'(s) < cfg.rank;
    assign prod   = acc[s-1] * size_s;
    assign step   = active
                    ? prod[ADDR_BITS-1:0] + ADDR_BITS'(idx[s-1][s*EXT_BITS +: EXT_BITS])
                    : acc[s-1];

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[s] <= 1'b0;
      end else if (en[s]) begin
        valid[s] <= valid[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        acc[s]   <= step;
        idx[s]   <= idx[s-1];
        value[s] <= value[s-1];
        flags[s] <= flags[s-1];
      end
    end
  end

  assign out_valid   = valid[LAST];
  assign out_address = acc[LAST];
  assign out_value   = value[LAST];
  assign out_flags   = flags[LAST];

endmodule

`default_nettype wire

// ===== hdl/slice_scatter_address_gen.sv =====
// channel   | group  | dir | payload
// ----------+--------+-----+------------------------------------------------
// gradient  | s_*    | in  | tdata: grad_value[31:0]
// address   | m_*    | out | tdata: write_address, write_value; tlast: last;
//           |        |     | tuser: out_of_range
// config    | cfg_*  | in  | index 0..7, data up to 9 bits, write on cfg_we
//
// one item per cycle sustained while m_tready holds; each item passes the queue
// and the horner pipeline (MAX_RANK stages: the first loads the outer index,
// each later one multiply-adds a dimension, the last is the output register)
// a two-entry queue parts the position counter from the address pipeline,
// so s_tready only drops once the pipeline is full and the queue holds two
// synchronous reset clears the position counter, queue and pipeline valids;
// configuration returns to rank 1, unit sizes, slice_dim 0, start 0, length 1
`default_nettype none

module slice_scatter_address_gen #(
  parameter int MAX_RANK  = 4,
  parameter int WORD_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // gradient items in
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,    // [31:0] grad_value
  // address items out
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,    // [31:0] write_address, [63:32] write_value
  output logic             m_tlast,    // last element of the slice tensor
  output logic [0:0]       m_tuser,    // [0] out_of_range
  // configuration writes
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [8:0]  cfg_data
);
  import ssag_pkg::*;

  localparam int QW = MAX_RANK * EXT_BITS + VALUE_BITS + 2;

  // bits at and above WORD_BITS are dropped from the word
  localparam logic [VALUE_BITS-1:0] VALUE_MASK =
    (WORD_BITS >= VALUE_BITS) ? '1 : VALUE_BITS'((64'd1 << WORD_BITS) - 64'd1);

  // raw configuration registers
  logic [2:0]            rank;
  logic [EXT_BITS-1:0]   size [NUM_SIZE];
  logic [SD_BITS-1:0]    slice_dim;
  logic [START_BITS-1:0] slice_start;
  logic [EXT_BITS-1:0]   slice_length;

  cfg_t                  cfg;
  logic [RANK_BITS-1:0]  rank_eff;
  logic signed [4:0]     sd_sum;

  logic                         accept;
  logic [MAX_RANK*EXT_BITS-1:0] f_idx;
  flags_t                       f_flags;
  logic [QW-1:0]                q_wdata;
  logic [QW-1:0]                q_rdata;
  queue_status_t                q_status;
  logic                         q_pop;

  logic [ADDR_BITS-1:0]         b_address;
  logic [VALUE_BITS-1:0]        b_value;
  flags_t                       b_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      rank         <= 3'd1;
      for (int i = 0; i < NUM_SIZE; i++) size[i] <= 9'd1;
      slice_dim    <= '0;
      slice_start  <= '0;
      slice_length <= 9'd1;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_RANK:         rank         <= cfg_data[2:0];
        REG_SIZE_0:       size[0]      <= cfg_data;
        REG_SIZE_1:       size[1]      <= cfg_data;
        REG_SIZE_2:       size[2]      <= cfg_data;
        REG_SIZE_3:       size[3]      <= cfg_data;
        REG_SLICE_DIM:    slice_dim    <= cfg_data[SD_BITS-1:0];
        REG_SLICE_START:  slice_start  <= cfg_data[START_BITS-1:0];
        REG_SLICE_LENGTH: slice_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // rank zero acts as one, rank above MAX_RANK saturates
  always_comb begin
    rank_eff = {1'b0, rank};
    if (rank == 3'd0) rank_eff = 4'd1;
    else if ({1'b0, rank} > RANK_BITS'(MAX_RANK)) rank_eff = RANK_BITS'(MAX_RANK);
  end

  // negative slice_dim counts from the end; outside the rank means no slice
  always_comb begin
    sd_sum = {{2{slice_dim[SD_BITS-1]}}, slice_dim};
    if (slice_dim[SD_BITS-1]) sd_sum = sd_sum + $signed({1'b0, rank_eff});
  end

  always_comb begin
    cfg.rank      = rank_eff;
    cfg.sd_valid  = !sd_sum[4] && (sd_sum[3:0] < rank_eff);
    cfg.sd        = sd_sum[SD_BITS-1:0];
    cfg.start     = slice_start;
    cfg.slice_len = sat_extent(slice_length);
    for (int i = 0; i < NUM_SIZE; i++) cfg.size[i] = sat_extent(size[i]);
  end

  assign s_tready = !q_status.full;
  assign accept   = s_tvalid & s_tready;

  // position counter and per-item classification
  ssag_front #(
    .MAX_RANK (MAX_RANK)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .accept (accept),
    .idx    (f_idx),
    .flags  (f_flags)
  );

  assign q_wdata = {s_tdata & VALUE_MASK, f_flags, f_idx};

  ssag_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (accept),
    .wdata  (q_wdata),
    .pop    (q_pop),
    .rdata  (q_rdata),
    .status (q_status)
  );

  // address pipeline
  ssag_back #(
    .MAX_RANK (MAX_RANK)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (!q_status.empty),
    .in_idx      (q_rdata[MAX_RANK*EXT_BITS-1:0]),
    .in_value    (q_rdata[QW-1 -: VALUE_BITS]),
    .in_flags    (q_rdata[MAX_RANK*EXT_BITS +: 2]),
    .in_take     (q_pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_address (b_address),
    .out_value   (b_value),
    .out_flags   (b_flags)
  );

  assign m_tdata    = {b_value, b_address};
  assign m_tlast    = b_flags.last;
  assign m_tuser[0] = b_flags.oor;

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid && q_status.empty)
    else $error("output valid or queue not empty after reset");

  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    accept |=> !q_status.empty)
    else $error("accepted item missing from queue");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_status.empty)
    else $error("pipeline took an item from an empty queue");
`endif

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
module tb;
  import ssag_pkg::*;

  // no accepted item on either side for this many cycles ends the run
  localparam int STALL_LIMIT = 4000;
  // settling wait after each batch, once every write has come back
  localparam int PIPE_DRAIN  = 8;
  // random stimulus stops once this many items have been queued
  localparam int RANDOM_ITEMS = 400;

  typedef struct {
    logic [31:0] addr;
    logic [31:0] value;
    logic        last;
    logic        oor;
  } scatter_write_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;    // [31:0] grad_value
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;         // [31:0] write_address, [63:32] write_value
  logic        m_tlast;
  logic [0:0]  m_tuser;         // [0] out_of_range
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [8:0]  cfg_data = '0;

  // gradient words waiting for the driver, and writes still owed by the block
  logic [31:0]    grad_words[$];
  logic [31:0]    corner_words[$];
  scatter_write_t pending_writes[$];

  // shadow copy of the registers, reset values
  logic [2:0] rank_r  = 3'd1;
  logic [8:0] size_r[4] = '{9'd1, 9'd1, 9'd1, 9'd1};
  logic [2:0] sdim_r  = 3'd0;
  logic [7:0] start_r = 8'd0;
  logic [8:0] slen_r  = 9'd1;
  // shadow of the multi-dimensional position counter
  logic [7:0] pos[4] = '{8'd0, 8'd0, 8'd0, 8'd0};

  // percent of cycles in which each side holds back
  int send_idle = 0;
  int recv_idle = 0;
  int errors = 0;
  int stall_cycles = 0;

  slice_scatter_address_gen u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #1 clk = ~clk;

  // zero reads as one, past 256 saturates
  function automatic int unsigned clamp_extent(input logic [8:0] v);
    if (v == 0) return 1;
    if (v > 256) return 256;
    return v;
  endfunction

  // address of the next slice element, then step the position counter
  function automatic scatter_write_t predict_write(input logic [31:0] grad);
    scatter_write_t    w;
    int                r;
    int                sd;
    int                d;
    int unsigned       ext[4];
    int unsigned       dim_size;
    int unsigned       idx;
    longint unsigned   addr;
    longint unsigned   stride;
    logic              fin;
    logic              oor;
    r = (rank_r == 0) ? 1 : (rank_r > 4) ? 4 : int'(rank_r);
    // negative dimension counts from the end; still outside means no slicing
    sd = $signed(sdim_r);
    if (sd < 0) sd += r;
    if (sd < 0 || sd >= r) sd = -1;
    addr = 0;
    stride = 1;
    fin = 1'b1;
    oor = 1'b0;
    // horner walk from the innermost dimension out
    for (d = r - 1; d >= 0; d--) begin
      dim_size = clamp_extent(size_r[d]);
      ext[d] = (d == sd) ? clamp_extent(slen_r) : dim_size;
      idx = pos[d];
      if (d == sd) begin
        idx += start_r;
        if (idx >= dim_size) oor = 1'b1;
      end
      addr += idx * stride;
      stride *= dim_size;
      if (pos[d] + 1 < ext[d]) fin = 1'b0;
    end
    // last element clears every counter in use, else ripple carry
    if (fin) begin
      for (d = 0; d < r; d++) pos[d] = '0;
    end else begin
      for (d = r - 1; d >= 0; d--) begin
        if (pos[d] + 1 >= ext[d]) begin
          pos[d] = '0;
        end else begin
          pos[d] = pos[d] + 8'd1;
          break;
        end
      end
    end
    w.addr  = addr[31:0];
    w.value = grad;
    w.last  = fin;
    w.oor   = oor;
    return w;
  endfunction

  // one register write per cycle; the shadow is updated as the write is driven
  task automatic write_reg(input reg_index_t idx, input logic [8:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_RANK:         rank_r    = val[2:0];
      REG_SIZE_0:       size_r[0] = val;
      REG_SIZE_1:       size_r[1] = val;
      REG_SIZE_2:       size_r[2] = val;
      REG_SIZE_3:       size_r[3] = val;
      REG_SLICE_DIM:    sdim_r    = val[2:0];
      REG_SLICE_START:  start_r   = val[7:0];
      REG_SLICE_LENGTH: slen_r    = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input int rank, input int s0, input int s1, input int s2,
                            input int s3, input int sd, input int start, input int len);
    write_reg(REG_RANK,         9'(rank));
    write_reg(REG_SIZE_0,       9'(s0));
    write_reg(REG_SIZE_1,       9'(s1));
    write_reg(REG_SIZE_2,       9'(s2));
    write_reg(REG_SIZE_3,       9'(s3));
    write_reg(REG_SLICE_DIM,    9'(sd & 7));
    write_reg(REG_SLICE_START,  9'(start));
    write_reg(REG_SLICE_LENGTH, 9'(len));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly tiny extents so the counters wrap often, sometimes the edges
  function automatic int pick_extent();
    case ($urandom_range(15))
      0:       return 0;
      1:       return 256;
      2:       return $urandom_range(511, 257);
      3:       return $urandom_range(255, 5);
      default: return $urandom_range(4, 1);
    endcase
  endfunction

  // queue n items, then hold the sender until every write has come back
  task automatic run_batch(input int n);
    @(negedge clk);
    repeat (n) begin
      if (corner_words.size() != 0) grad_words.push_back(corner_words.pop_front());
      else grad_words.push_back($urandom());
    end
    do @(negedge clk);
    while (grad_words.size() != 0 || s_tvalid || pending_writes.size() != 0);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  // driver: present the next word once the current one is taken
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) pending_writes.push_back(predict_write(s_tdata));
      if (!s_tvalid || s_tready) begin
        if (grad_words.size() != 0 && $urandom_range(99) >= send_idle) begin
          s_tvalid <= 1'b1;
          s_tdata  <= grad_words.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each write item against the oldest prediction
  always @(posedge clk) begin : monitor
    scatter_write_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_writes.size() == 0) begin
          $error("unexpected write item: address %h", m_tdata[31:0]);
          errors++;
        end else begin
          want = pending_writes.pop_front();
          if (m_tdata[31:0] !== want.addr) begin
            $error("write_address: expected %h, got %h", want.addr, m_tdata[31:0]);
            errors++;
          end
          if (m_tdata[63:32] !== want.value) begin
            $error("write_value: expected %h, got %h", want.value, m_tdata[63:32]);
            errors++;
          end
          if (m_tlast !== want.last) begin
            $error("last: expected %b, got %b", want.last, m_tlast);
            errors++;
          end
          if (m_tuser[0] !== want.oor) begin
            $error("out_of_range: expected %b, got %b", want.oor, m_tuser[0]);
            errors++;
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // watchdog on cycles with no accepted item on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("slice_scatter_address_gen: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int rand_sent;
    int n;
    rand_sent = 0;
    // data extremes and alternating bit patterns for the directed part
    corner_words = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0001, 32'hFFFF_FFFE,
                     32'h0F0F_F0F0, 32'hF0F0_0F0F, 32'h8000_0001, 32'h0000_FFFF,
                     32'hFFFF_0000, 32'h1234_5678, 32'hDEAD_BEEF, 32'h0101_0101,
                     32'hFEFE_FEFE, 32'h7F7F_7F7F};
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_idle = 18;
    recv_idle = 83;
    // reset configuration: single element tensor, every item is last
    run_batch(2);
    // one long dimension, leaves the outer counter at one
    set_config(1, 256, 1, 1, 1, 0, 0, 256);
    run_batch(1);
    // full-size rank 4, slice dim given as -4, offset index 256 wraps past 2^32
    set_config(4, 256, 256, 256, 256, -4, 255, 256);
    run_batch(2);
    // rank zero, size and length zero, slice dim -1, start beyond the size
    set_config(0, 0, 1, 1, 1, -1, 3, 0);
    run_batch(3);
    // rank above the maximum, oversized extents and length
    set_config(7, 300, 511, 2, 3, 3, 1, 400);
    run_batch(4);
    // slice dim still outside the rank after normalization: nothing sliced
    set_config(2, 2, 3, 1, 1, -4, 0, 5);
    run_batch(6);

    // random settings, counters carried across each change
    while (rand_sent < RANDOM_ITEMS) begin
      if (rand_sent < RANDOM_ITEMS / 3) begin
        send_idle = 18;
        recv_idle = 83;
      end else if (rand_sent < 2 * RANDOM_ITEMS / 3) begin
        send_idle = 83;
        recv_idle = 18;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      set_config(($urandom_range(7) == 0) ? $urandom_range(7) : $urandom_range(4, 1),
                 pick_extent(), pick_extent(), pick_extent(), pick_extent(),
                 $urandom_range(7),
                 ($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(3),
                 pick_extent());
      n = $urandom_range(40, 10);
      run_batch(n);
      rand_sent += n;
    end

    if (errors == 0 && pending_writes.size() == 0) begin
      $display("slice_scatter_address_gen: match");
    end else begin
      $display("slice_scatter_address_gen: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/ssag_pkg.sv
hdl/ssag_front.sv
hdl/ssag_queue.sv
hdl/ssag_back.sv
hdl/slice_scatter_address_gen.sv
verif/tb.sv
